[rtl/icalc_pkg.sv]
// Shared constants, codes and types of the infix integer calculator.
package icalc_pkg;

  localparam int MAX_OPERAND_CHARS_DEF = 31;
  localparam int VALUE_BITS_DEF        = 32;

  localparam int CH_W     = 8;
  localparam int STATUS_W = 2;
  localparam int VALUE_W  = 32;

  localparam logic [CH_W-1:0] CH_NUL   = 8'd0;
  localparam logic [CH_W-1:0] CH_LF    = 8'd10;
  localparam logic [CH_W-1:0] CH_CR    = 8'd13;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_DIV_ZERO = 2'd2
  } status_e;

  // Control part of one evaluation request from the parser to the ALU.
  typedef struct packed {
    logic valid;
    logic invalid;
    op_e  op;
  } job_ctl_t;

endpackage

[rtl/icalc_parser.sv]
// Character parser: tracks the line phase and accumulates both operands.
module icalc_parser #(
  parameter int MAX_OPERAND_CHARS = icalc_pkg::MAX_OPERAND_CHARS_DEF,
  parameter int VALUE_BITS        = icalc_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [icalc_pkg::CH_W-1:0]   ch_i,
  output icalc_pkg::job_ctl_t          job_o,
  output logic [VALUE_BITS-1:0]        a_o,
  output logic [VALUE_BITS-1:0]        b_o
);
  import icalc_pkg::*;

  localparam int LEN_W = $clog2(MAX_OPERAND_CHARS + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_OPERAND_CHARS);

  typedef enum logic [5:0] {
    PH_LEAD  = 6'b000001,
    PH_LDIG  = 6'b000010,
    PH_LSP   = 6'b000100,
    PH_RLEAD = 6'b001000,
    PH_RDIG  = 6'b010000,
    PH_TRAIL = 6'b100000
  } phase_e;

  phase_e phase_q, phase_d;
  logic invalid_q, invalid_d;
  logic nonempty_q, nonempty_d;
  logic trunc_q, trunc_d;

  logic [VALUE_BITS-1:0] lval_q, lval_d, rval_q, rval_d;
  logic                  lneg_q, lneg_d, rneg_q, rneg_d;
  logic [LEN_W-1:0]      llen_q, llen_d, rlen_q, rlen_d;
  op_e                   op_q, op_d;

  logic                  is_end, is_digit, is_space, is_minus, is_op;
  op_e                   ch_op;
  logic [VALUE_BITS-1:0] acc_src, acc_new;

  always_comb begin
    is_end   = (ch_i == CH_LF) || (ch_i == CH_CR);
    is_digit = (ch_i >= CH_ZERO) && (ch_i <= CH_NINE);
    is_space = (ch_i == CH_SPACE);
    is_minus = (ch_i == CH_MINUS);
    is_op    = 1'b1;
    ch_op    = OP_ADD;
    case (ch_i)
      CH_PLUS:  ch_op = OP_ADD;
      CH_MINUS: ch_op = OP_SUB;
      CH_STAR:  ch_op = OP_MUL;
      CH_SLASH: ch_op = OP_DIV;
      default:  is_op = 1'b0;
    endcase
  end

  // One decimal digit per character: v * 10 + d, wrapping at the value width.
  always_comb begin
    case (phase_q)
      PH_LDIG: acc_src = lval_q;
      PH_RDIG: acc_src = rval_q;
      default: acc_src = '0;
    endcase
    acc_new = {acc_src[VALUE_BITS-4:0], 3'b000} + {acc_src[VALUE_BITS-2:0], 1'b0}
            + VALUE_BITS'(ch_i[3:0]);
  end

  always_comb begin
    phase_d    = phase_q;
    invalid_d  = invalid_q;
    nonempty_d = nonempty_q;
    trunc_d    = trunc_q;
    lval_d     = lval_q;
    lneg_d     = lneg_q;
    llen_d     = llen_q;
    rval_d     = rval_q;
    rneg_d     = rneg_q;
    rlen_d     = rlen_q;
    op_d       = op_q;
    if (accept_i) begin
      if (is_end) begin
        phase_d    = PH_LEAD;
        invalid_d  = 1'b0;
        nonempty_d = 1'b0;
        trunc_d    = 1'b0;
      end else begin
        nonempty_d = 1'b1;
        if (!trunc_q) begin
          if (ch_i == CH_NUL) begin
            trunc_d = 1'b1;
          end else begin
            case (phase_q)
              PH_LEAD: begin
                if (is_minus) begin
                  lval_d  = '0;
                  lneg_d  = 1'b1;
                  llen_d  = LEN_W'(1);
                  phase_d = PH_LDIG;
                end else if (is_digit) begin
                  lval_d  = acc_new;
                  lneg_d  = 1'b0;
                  llen_d  = LEN_W'(1);
                  phase_d = PH_LDIG;
                end else if (!is_space) begin
                  invalid_d = 1'b1;
                end
              end
              PH_LDIG, PH_LSP: begin
                if ((phase_q == PH_LDIG) && is_digit) begin
                  if (llen_q >= LEN_MAX) begin
                    invalid_d = 1'b1;
                  end else begin
                    lval_d = acc_new;
                    llen_d = llen_q + LEN_W'(1);
                  end
                end else if (is_space) begin
                  phase_d = PH_LSP;
                end else if (is_op) begin
                  op_d    = ch_op;
                  phase_d = PH_RLEAD;
                end else begin
                  invalid_d = 1'b1;
                end
              end
              PH_RLEAD: begin
                if (is_minus) begin
                  rval_d  = '0;
                  rneg_d  = 1'b1;
                  rlen_d  = LEN_W'(1);
                  phase_d = PH_RDIG;
                end else if (is_digit) begin
                  rval_d  = acc_new;
                  rneg_d  = 1'b0;
                  rlen_d  = LEN_W'(1);
                  phase_d = PH_RDIG;
                end else if (!is_space) begin
                  invalid_d = 1'b1;
                end
              end
              PH_RDIG: begin
                if (is_digit) begin
                  if (rlen_q >= LEN_MAX) begin
                    invalid_d = 1'b1;
                  end else begin
                    rval_d = acc_new;
                    rlen_d = rlen_q + LEN_W'(1);
                  end
                end else if (is_space) begin
                  phase_d = PH_TRAIL;
                end else begin
                  invalid_d = 1'b1;
                end
              end
              default: begin
                if (!is_space) begin
                  invalid_d = 1'b1;
                end
              end
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_LEAD;
      invalid_q  <= 1'b0;
      nonempty_q <= 1'b0;
      trunc_q    <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      invalid_q  <= invalid_d;
      nonempty_q <= nonempty_d;
      trunc_q    <= trunc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lval_q <= lval_d;
    lneg_q <= lneg_d;
    llen_q <= llen_d;
    rval_q <= rval_d;
    rneg_q <= rneg_d;
    rlen_q <= rlen_d;
    op_q   <= op_d;
  end

  // An operand has no digits when its length counts only the sign.
  always_comb begin
    job_o.valid   = accept_i && is_end && nonempty_q;
    job_o.invalid = invalid_q || !((phase_q == PH_RDIG) || (phase_q == PH_TRAIL))
                  || (llen_q == LEN_W'(lneg_q)) || (rlen_q == LEN_W'(rneg_q));
    job_o.op      = op_q;
    a_o           = lneg_q ? (VALUE_BITS'(0) - lval_q) : lval_q;
    b_o           = rneg_q ? (VALUE_BITS'(0) - rval_q) : rval_q;
  end

endmodule

[rtl/icalc_alu.sv]
// Bit-serial arithmetic unit with the output word register.
module icalc_alu #(
  parameter int VALUE_BITS = icalc_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  icalc_pkg::job_ctl_t                 job_i,
  input  logic [VALUE_BITS-1:0]               a_i,
  input  logic [VALUE_BITS-1:0]               b_i,
  output logic                                ready_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [icalc_pkg::STATUS_W-1:0]      status_o,
  output logic signed [icalc_pkg::VALUE_W-1:0] value_o
);
  import icalc_pkg::*;

  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EVAL = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_FIN  = 5'b10000
  } alu_state_e;

  alu_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;

  logic [VALUE_BITS-1:0] a_q, a_d, b_q, b_d, acc_q, acc_d;
  logic                  inv_q, inv_d, sgn_q, sgn_d;
  op_e                   op_q, op_d;
  status_e               st_q, st_d;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic [VALUE_W-1:0]    value_q, value_d;

  logic [VALUE_BITS-1:0] ma, mb, res;
  logic [VALUE_BITS:0]   rem_sh, diff;
  logic [VALUE_W-1:0]    res32;
  logic                  load_out;

  always_comb begin
    ma     = a_q[VALUE_BITS-1] ? (VALUE_BITS'(0) - a_q) : a_q;
    mb     = b_q[VALUE_BITS-1] ? (VALUE_BITS'(0) - b_q) : b_q;
    rem_sh = {acc_q, a_q[VALUE_BITS-1]};
    diff   = rem_sh - {1'b0, b_q};
    if (op_q == OP_DIV) begin
      res = sgn_q ? (VALUE_BITS'(0) - a_q) : a_q;
    end else begin
      res = acc_q;
    end
  end

  if (VALUE_BITS >= VALUE_W) begin : g_trunc
    assign res32 = res[VALUE_W-1:0];
  end else begin : g_sext
    assign res32 = {{(VALUE_W - VALUE_BITS){res[VALUE_BITS-1]}}, res};
  end

  assign load_out = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    a_d         = a_q;
    b_d         = b_q;
    acc_d       = acc_q;
    inv_d       = inv_q;
    sgn_d       = sgn_q;
    op_d        = op_q;
    st_d        = st_q;
    status_d    = status_q;
    value_d     = value_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (job_i.valid) begin
          a_d     = a_i;
          b_d     = b_i;
          inv_d   = job_i.invalid;
          op_d    = job_i.op;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        st_d    = ST_OK;
        cnt_d   = CNT_W'(VALUE_BITS);
        state_d = S_FIN;
        if (inv_q) begin
          st_d = ST_INVALID;
        end else begin
          case (op_q)
            OP_ADD: acc_d = a_q + b_q;
            OP_SUB: acc_d = a_q - b_q;
            OP_MUL: begin
              acc_d   = '0;
              state_d = S_MUL;
            end
            default: begin
              a_d   = ma;
              b_d   = mb;
              sgn_d = a_q[VALUE_BITS-1] ^ b_q[VALUE_BITS-1];
              acc_d = '0;
              if (mb == '0) begin
                st_d = ST_DIV_ZERO;
              end else begin
                state_d = S_DIV;
              end
            end
          endcase
        end
      end
      S_MUL: begin
        // Shift-and-add: one multiplier bit per cycle, low half kept.
        if (b_q[0]) begin
          acc_d = acc_q + a_q;
        end
        a_d   = {a_q[VALUE_BITS-2:0], 1'b0};
        b_d   = {1'b0, b_q[VALUE_BITS-1:1]};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = S_FIN;
        end
      end
      S_DIV: begin
        // Restoring division: the dividend shifts out of a_q as quotient bits shift in.
        if (!diff[VALUE_BITS]) begin
          acc_d = diff[VALUE_BITS-1:0];
          a_d   = {a_q[VALUE_BITS-2:0], 1'b1};
        end else begin
          acc_d = rem_sh[VALUE_BITS-1:0];
          a_d   = {a_q[VALUE_BITS-2:0], 1'b0};
        end
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          status_d    = st_q;
          value_d     = (st_q == ST_OK) ? res32 : '0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    b_q      <= b_d;
    acc_q    <= acc_d;
    inv_q    <= inv_d;
    sgn_q    <= sgn_d;
    op_q     <= op_d;
    st_q     <= st_d;
    status_q <= status_d;
    value_q  <= value_d;
  end

  assign ready_o     = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign value_o     = value_q;

endmodule

[rtl/infix_integer_calculator_core.sv]
// Top level of the infix integer calculator: parser plus bit-serial ALU.
//
// Input channel: one ASCII character per word on ch_i (in_valid_i/in_ready_o).
// A line is [spaces][-]digits[spaces]op[spaces][-]digits[spaces], op one of
// + - * /, ended by LF or CR. A NUL byte makes the rest of the line ignored.
// Output channel: one word per non-empty line on status_o/value_o
// (out_valid_o/out_ready_i); status 0 ok, 1 invalid, 2 division by zero,
// value is zero unless the status is ok. Empty lines give no word.
// Ordinary characters are taken one per cycle while in_ready_o is high.
// A line end starts the ALU, which goes through S_EVAL, then S_MUL or S_DIV
// for a valid * or / line (S_DIV only with a nonzero divisor), then S_FIN,
// which loads the output register once it is free. The shift-and-add
// multiply and restoring divide each take one bit per cycle. in_ready_o
// is low while the ALU works on a line, from S_EVAL until it returns to
// S_IDLE on loading the output register.
// One finished word is held in the output register while the receiver
// stalls; parsing of the next line goes on meanwhile, and the next result
// waits in the ALU, with in_ready_o low, until that register is free.
// Reset returns the parser to the start of a line and empties the output.
module infix_integer_calculator_core #(
  parameter int MAX_OPERAND_CHARS = icalc_pkg::MAX_OPERAND_CHARS_DEF,
  parameter int VALUE_BITS        = icalc_pkg::VALUE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [icalc_pkg::CH_W-1:0]           ch_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [icalc_pkg::STATUS_W-1:0]       status_o,
  output logic signed [icalc_pkg::VALUE_W-1:0] value_o
);
  import icalc_pkg::*;

  job_ctl_t              job;
  logic [VALUE_BITS-1:0] op_a, op_b;
  logic                  alu_ready;
  logic                  in_accept;

  assign in_ready_o = alu_ready;
  assign in_accept  = in_valid_i && alu_ready;

  icalc_parser #(
    .MAX_OPERAND_CHARS (MAX_OPERAND_CHARS),
    .VALUE_BITS        (VALUE_BITS)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .ch_i     (ch_i),
    .job_o    (job),
    .a_o      (op_a),
    .b_o      (op_b)
  );

  icalc_alu #(
    .VALUE_BITS (VALUE_BITS)
  ) u_alu (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job),
    .a_i         (op_a),
    .b_i         (op_b),
    .ready_o     (alu_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .value_o     (value_o)
  );

  // A word that reports an error carries a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (value_o == '0))
    else $error("error word with nonzero value");

  // Only the three defined status codes ever leave the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((status_o == ST_OK) || (status_o == ST_INVALID)
                     || (status_o == ST_DIV_ZERO)))
    else $error("undefined status code");

  // A new word is loaded only from the final ALU state, while input is held off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result word appeared without an ALU pass");

  // A line end with pending characters must start the ALU, which then drops ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job.valid |=> !in_ready_o)
    else $error("line end did not start the ALU");

endmodule
